FILE: rtl/matrix4_multiply_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply unit
// Concurrent checks that are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_MULTIPLY_UNIT_ASSERT_SVH
`define MATRIX4_MULTIPLY_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MM4_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MM4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MM4_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define MM4_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply package
// Sizes, widths and shared types of the matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int CELLS     = DIM * DIM;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 4;
   localparam int ROW_W     = $clog2(DIM);
   localparam int POS_W     = $clog2(CELLS);
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int TERM_W    = PROD_W - FRAC_BITS;
   localparam int SUM_W     = TERM_W + $clog2(DIM);

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [TERM_W-1:0]  term_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] col;
      logic [POS_W-1:0] pos;
      logic             last;
   } tag_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [ROW_W-1:0]   col;
      logic [VALUE_W-1:0] left_value;
      logic [VALUE_W-1:0] right_value;
   } load_type;

   function automatic logic [INDEX_W-1:0] pos_to_index(input logic [POS_W-1:0] pos);
      logic [POS_W+INDEX_W-1:0] wide;
      wide = {{INDEX_W{1'b0}}, pos};
      return wide[INDEX_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mm4_interfaces.sv
// ----------------------------------------------------------------------------
// Matrix multiply channels
// Valid/ready channels for element pairs in and product elements out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mm4_req_if import mm4_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type left_value;
   value_type right_value;

   modport source (output valid, output left_value, output right_value, input ready);
   modport sink (input valid, input left_value, input right_value, output ready);
endinterface

interface mm4_rsp_if import mm4_pkg::*; ();
   logic               valid;
   logic               ready;
   value_type          product_value;
   logic [INDEX_W-1:0] element_index;
   logic               saturated_flag;
   logic               last_flag;

   modport source (output valid, output product_value, output element_index,
                   output saturated_flag, output last_flag, input ready);
   modport sink (input valid, input product_value, input element_index,
                 input saturated_flag, input last_flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/mm4_cell.sv
// ----------------------------------------------------------------------------
// Matrix multiply cell
// Holds one column of the left matrix and one row of the right matrix,
// multiplies the pair selected by the passing tag and adds the term to the
// partial sum handed on from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_cell import mm4_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    advance,
   input  wire load_type load,
   input  wire logic    left_we,
   input  wire logic    right_we,
   input  wire tag_type up_tag,
   input  wire sum_type up_sum,
   output tag_type      dn_tag,
   output sum_type      dn_sum
);

   value_type left_col_ff [DIM];
   value_type right_row_ff [DIM];

   tag_type   a_tag_ff;
   sum_type   a_sum_ff;
   prod_type  prod_ff;
   prod_type  prod_in;
   term_type  term;
   sum_type   sum_in;
   tag_type   dn_tag_ff;
   sum_type   dn_sum_ff;
   value_type left_op;
   value_type right_op;

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_col_ff[load.row] <= load.left_value;
      end
      if (right_we) begin
         right_row_ff[load.col] <= load.right_value;
      end
   end

   assign left_op  = left_col_ff[up_tag.row];
   assign right_op = right_row_ff[up_tag.col];
   assign prod_in  = prod_type'(left_op) * prod_type'(right_op);
   assign term     = TERM_W'(prod_ff >>> FRAC_BITS);
   assign sum_in   = a_sum_ff + SUM_W'(term);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff.valid  <= 1'b0;
         dn_tag_ff.valid <= 1'b0;
      end else if (advance) begin
         a_tag_ff  <= up_tag;
         dn_tag_ff <= a_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_sum_ff  <= up_sum;
         prod_ff   <= prod_in;
         dn_sum_ff <= sum_in;
      end
   end

   assign dn_tag = dn_tag_ff;
   assign dn_sum = dn_sum_ff;

endmodule

`default_nettype wire

FILE: rtl/mm4_output_stage.sv
// ----------------------------------------------------------------------------
// Matrix multiply output stage
// Saturates the finished sum to 32 bits and holds the result item until the
// sink takes it; the chain advances whenever this register can load.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_output_stage import mm4_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire tag_type in_tag,
   input  wire sum_type in_sum,
   output logic         advance,
   mm4_rsp_if.source    rsp
);

   logic [SUM_W-VALUE_W:0] high_bits;
   logic                   fits;
   value_type              value_in;
   logic                   rsp_valid_ff;
   value_type              value_ff;
   logic [INDEX_W-1:0]     index_ff;
   logic                   sat_ff;
   logic                   last_ff;

   assign high_bits = in_sum[SUM_W-1:VALUE_W-1];
   assign fits      = (&high_bits) | ~(|high_bits);

   always_comb begin
      if (fits) begin
         value_in = in_sum[VALUE_W-1:0];
      end else if (in_sum[SUM_W-1]) begin
         value_in = VALUE_MIN;
      end else begin
         value_in = VALUE_MAX;
      end
   end

   assign advance = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
         index_ff <= pos_to_index(in_tag.pos);
         sat_ff   <= !fits;
         last_ff  <= in_tag.last;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.product_value  = value_ff;
   assign rsp.element_index  = index_ff;
   assign rsp.saturated_flag = sat_ff;
   assign rsp.last_flag      = last_ff;

endmodule

`default_nettype wire

FILE: rtl/matrix4_multiply_unit.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit
// Signed Q16.16 product of two 4x4 matrices loaded and emitted in
// column-major order, with saturation of each element.
// ----------------------------------------------------------------------------
// The unit takes one element pair per cycle while loading, left and right at the
// same column-major position, and after the sixteenth pair streams out the
// sixteen product elements in column-major order, last one flagged. The
// elements are formed by a chain of four multiply-accumulate cells, one per
// term of the dot product, each cell two register stages deep; the results
// leave one per cycle unless the sink stalls. The cells hold the operands,
// so the next matrix is taken only once the last result has been delivered.
`default_nettype none
`include "matrix4_multiply_unit_assert.svh"

module matrix4_multiply_unit import mm4_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mm4_req_if.sink   req_bus,
   mm4_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [ROW_W-1:0] ld_row_ff;
   logic [ROW_W-1:0] ld_col_ff;
   logic [POS_W-1:0] ld_pos_ff;
   logic [ROW_W-1:0] is_row_ff;
   logic [ROW_W-1:0] is_col_ff;
   logic [POS_W-1:0] is_pos_ff;
   logic             req_accept;
   logic             ld_last;
   logic             is_last;
   logic             advance;
   logic             rsp_done;
   load_type         load;
   logic [DIM-1:0]   left_we;
   logic [DIM-1:0]   right_we;
   tag_type          chain_tag [DIM+1];
   sum_type          chain_sum [DIM+1];

   assign req_bus.ready = (state_ff == ST_LOAD);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign ld_last       = (ld_pos_ff == POS_W'(CELLS - 1));
   assign is_last       = (is_pos_ff == POS_W'(CELLS - 1));
   assign rsp_done      = rsp_bus.valid && rsp_bus.ready && rsp_bus.last_flag;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept && ld_last) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (advance && is_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         ld_row_ff <= '0;
         ld_col_ff <= '0;
         ld_pos_ff <= '0;
         is_row_ff <= '0;
         is_col_ff <= '0;
         is_pos_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            if (ld_row_ff == ROW_W'(DIM - 1)) begin
               ld_row_ff <= '0;
               ld_col_ff <= ld_last ? '0 : ROW_W'(ld_col_ff + 1'b1);
            end else begin
               ld_row_ff <= ROW_W'(ld_row_ff + 1'b1);
            end
            ld_pos_ff <= ld_last ? '0 : POS_W'(ld_pos_ff + 1'b1);
         end
         if (state_ff == ST_ISSUE && advance) begin
            if (is_row_ff == ROW_W'(DIM - 1)) begin
               is_row_ff <= '0;
               is_col_ff <= is_last ? '0 : ROW_W'(is_col_ff + 1'b1);
            end else begin
               is_row_ff <= ROW_W'(is_row_ff + 1'b1);
            end
            is_pos_ff <= is_last ? '0 : POS_W'(is_pos_ff + 1'b1);
         end
      end
   end

   assign load.row         = ld_row_ff;
   assign load.col         = ld_col_ff;
   assign load.left_value  = req_bus.left_value;
   assign load.right_value = req_bus.right_value;

   assign chain_tag[0].valid = (state_ff == ST_ISSUE);
   assign chain_tag[0].row   = is_row_ff;
   assign chain_tag[0].col   = is_col_ff;
   assign chain_tag[0].pos   = is_pos_ff;
   assign chain_tag[0].last  = is_last;
   assign chain_sum[0]       = '0;

   for (genvar e = 0; e < DIM; e++) begin : g_cell
      assign left_we[e]  = req_accept && (ld_col_ff == ROW_W'(e));
      assign right_we[e] = req_accept && (ld_row_ff == ROW_W'(e));

      mm4_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .load     (load),
         .left_we  (left_we[e]),
         .right_we (right_we[e]),
         .up_tag   (chain_tag[e]),
         .up_sum   (chain_sum[e]),
         .dn_tag   (chain_tag[e+1]),
         .dn_sum   (chain_sum[e+1])
      );
   end

   mm4_output_stage u_output_stage (
      .clock   (clock),
      .reset   (reset),
      .in_tag  (chain_tag[DIM]),
      .in_sum  (chain_sum[DIM]),
      .advance (advance),
      .rsp     (rsp_bus)
   );

   `MM4_ASSERT_IMPLIES(a_no_load_during_output, clock, reset, rsp_bus.valid, !req_bus.ready, "Input was open while a result item was pending.")
   `MM4_ASSERT_NEXT(a_reopen_after_last, clock, reset, rsp_done, req_bus.ready, "Input did not reopen after the last item was taken.")
   `MM4_ASSERT_IMPLIES(a_last_index, clock, reset, rsp_bus.valid && rsp_bus.last_flag, rsp_bus.element_index == pos_to_index(POS_W'(CELLS - 1)), "Last item carried the wrong element index.")
   `MM4_ASSERT_IMPLIES(a_saturated_value, clock, reset, rsp_bus.valid && rsp_bus.saturated_flag, rsp_bus.product_value == VALUE_MAX || rsp_bus.product_value == VALUE_MIN, "Saturated item does not hold a range limit.")
   `MM4_ASSERT_IMPLIES(a_load_count_idle, clock, reset, state_ff != ST_LOAD, ld_pos_ff == '0, "Load position moved while the product was in progress.")

endmodule

`default_nettype wire

FILE: dv/matrix4_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit testbench
// Streams 4x4 matrix pairs into the unit and checks every product element
// against a predictor that forms the Q16.16 dot products with floor shifts
// and 32-bit saturation. Both channels stall at random except in the final
// full-rate test.
// ----------------------------------------------------------------------------
module matrix4_multiply_unit_test import mm4_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 4 * (2 * DIM + 1);
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_MATRICES = 5;

   localparam value_type UNIT_VALUE   = value_type'(1 << FRAC_BITS);
   localparam value_type NEGATIVE_LSB = value_type'(-1);

   typedef struct packed {
      value_type          product;
      logic [INDEX_W-1:0] index;
      logic               clipped;
      logic               last;
   } element_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mm4_req_if req_bus();
   mm4_rsp_if rsp_bus();

   matrix4_multiply_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   value_type   left_cells[CELLS];
   value_type   right_cells[CELLS];
   int          fill_count = 0;
   element_type product_queue[$];

   logic        idle_enable = 1'b1;
   int          stall_left = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   element_type received;
   element_type predicted;

   always #2 clock = ~clock;

   // Stores one element pair and, on the last one, queues the whole product.
   function automatic void load_pair(input value_type l, input value_type r);
      prod_type    total;
      prod_type    term;
      element_type element;
      int          pos;
      left_cells[fill_count] = l;
      right_cells[fill_count] = r;
      if (fill_count + 1 < CELLS) begin
         fill_count++;
         return;
      end
      fill_count = 0;
      for (int col = 0; col < DIM; col++) begin
         for (int row = 0; row < DIM; row++) begin
            total = '0;
            for (int e = 0; e < DIM; e++) begin
               term = prod_type'(left_cells[row + e * DIM]) *
                      prod_type'(right_cells[e + col * DIM]);
               total += term >>> FRAC_BITS;
            end
            pos = row + DIM * col;
            element.index = pos[INDEX_W-1:0];
            element.last = (pos == CELLS - 1);
            if (total > prod_type'(VALUE_MAX)) begin
               element.product = VALUE_MAX;
               element.clipped = 1'b1;
            end else if (total < prod_type'(VALUE_MIN)) begin
               element.product = VALUE_MIN;
               element.clipped = 1'b1;
            end else begin
               element.product = total[VALUE_W-1:0];
               element.clipped = 1'b0;
            end
            product_queue.push_back(element);
         end
      end
   endfunction

   function automatic value_type pick_value();
      value_type v;
      case ($urandom_range(0, 5))
         0: v = value_type'($urandom);
         1: begin
            case ($urandom_range(0, 4))
               0: v = VALUE_MAX;
               1: v = VALUE_MIN;
               2: v = '0;
               3: v = NEGATIVE_LSB;
               default: v = UNIT_VALUE;
            endcase
         end
         default: v = $signed($urandom) >>> $urandom_range(8, 24);
      endcase
      return v;
   endfunction

   task automatic send_pair(input value_type l, input value_type r);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         req_bus.left_value <= value_type'($urandom);
         req_bus.right_value <= value_type'($urandom);
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.left_value <= l;
      req_bus.right_value <= r;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      load_pair(l, r);
   endtask

   // Rows of the left matrix and columns of the right one are chosen so that
   // some elements clip high, some clip low and the rest round toward minus
   // infinity.
   task automatic test_saturation_corners();
      value_type l;
      value_type r;
      int        row;
      int        col;
      idle_enable <= 1'b1;
      for (int pos = 0; pos < CELLS; pos++) begin
         row = pos % DIM;
         col = pos / DIM;
         case (row)
            0: l = VALUE_MAX;
            1: l = VALUE_MIN;
            2: l = '0;
            default: l = col[0] ? NEGATIVE_LSB : UNIT_VALUE;
         endcase
         case (col)
            0: r = VALUE_MAX;
            1: r = VALUE_MIN;
            2: r = UNIT_VALUE;
            default: r = NEGATIVE_LSB;
         endcase
         send_pair(l, r);
      end
   endtask

   task automatic test_random_matrices();
      idle_enable <= 1'b1;
      repeat (RANDOM_MATRICES * CELLS) send_pair(pick_value(), pick_value());
   endtask

   task automatic test_full_rate();
      idle_enable <= 1'b0;
      repeat (CELLS) send_pair(pick_value(), pick_value());
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         received = {rsp_bus.product_value, rsp_bus.element_index,
                     rsp_bus.saturated_flag, rsp_bus.last_flag};
         if (product_queue.size() == 0) begin
            $display("%0t: unexpected element, expected none, got index %0d value %h",
                     $time, received.index, received.product);
            error_count++;
         end else begin
            predicted = product_queue.pop_front();
            if (received !== predicted) begin
               $display("%0t: expected index %0d value %h sat %b last %b,",
                        $time, predicted.index, predicted.product,
                        predicted.clipped, predicted.last,
                        " got index %0d value %h sat %b last %b",
                        received.index, received.product,
                        received.clipped, received.last);
               error_count++;
            end
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d elements outstanding", $time, product_queue.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.left_value <= '0;
      req_bus.right_value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_saturation_corners();
      test_random_matrices();
      test_full_rate();
      req_bus.valid <= 1'b0;
      while (product_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/mm4_pkg.sv
rtl/mm4_interfaces.sv
rtl/mm4_cell.sv
rtl/mm4_output_stage.sv
rtl/matrix4_multiply_unit.sv
dv/matrix4_multiply_unit_test.sv
